### sv/sh24_pkg.sv
// Package for the SipHash-2-4 stream unit: item, job and result types,
// initialization constants and the round and fold functions.
// No dependencies.
package sh24_pkg;

   localparam logic [63:0] INIT_C0 = 64'h736f6d6570736575;
   localparam logic [63:0] INIT_C1 = 64'h646f72616e646f6d;
   localparam logic [63:0] INIT_C2 = 64'h6c7967656e657261;
   localparam logic [63:0] INIT_C3 = 64'h7465646279746573;

   localparam logic [7:0] TWEAK_NARROW = 8'hff;
   localparam logic [7:0] TWEAK_WIDE   = 8'hee;
   localparam logic [7:0] TWEAK_HIGH   = 8'hdd;

   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LOW     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_HIGH    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDE_OUTPUT = 2'd2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       message_end;
   } req_type;

   typedef struct packed {
      logic [63:0] hash_word;
      logic        final_word;
   } rsp_type;

   typedef enum logic [1:0] {
      JOB_WORD       = 2'd0,
      JOB_FINAL      = 2'd1,
      JOB_WORD_FINAL = 2'd2
   } job_kind_type;

   typedef struct packed {
      logic [63:0]  word;
      logic [7:0]   pad_len;
      logic         first;
      logic         wide;
      job_kind_type kind;
   } job_type;

   typedef logic [3:0][63:0] sip_state_type;

   function automatic logic [63:0] rotl(logic [63:0] x, int unsigned n);
      return (x << n) | (x >> (64 - n));
   endfunction

   function automatic sip_state_type sip_round(sip_state_type v);
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] c;
      logic [63:0] d;
      a = v[0];
      b = v[1];
      c = v[2];
      d = v[3];
      a = a + b;  b = rotl(b, 13); b = b ^ a; a = rotl(a, 32);
      c = c + d;  d = rotl(d, 16); d = d ^ c;
      a = a + d;  d = rotl(d, 21); d = d ^ a;
      c = c + b;  b = rotl(b, 17); b = b ^ c; c = rotl(c, 32);
      return {d, c, b, a};
   endfunction

   function automatic logic [63:0] fold(sip_state_type v);
      return v[0] ^ v[1] ^ v[2] ^ v[3];
   endfunction

endpackage

### sv/sh24_front.sv
// Front end: accepts byte items, packs little-endian words, tracks count and
// length, and pushes compression jobs. Depends on sh24_pkg.
module sh24_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sh24_pkg::req_type req_data,
   input  logic             wide_output,
   output logic             push_valid,
   output sh24_pkg::job_type push_job,
   input  logic             push_full
);
   import sh24_pkg::*;

   logic [6:0][7:0] pend_ff, pend_in, pend_new;
   logic [2:0]      count_ff, count_in;
   logic [7:0]      len_ff, len_in;
   logic            open_ff, open_in;
   logic            wide_ff, wide_in;
   logic            first_ff, first_in;

   logic            accept;
   logic            active;
   logic [2:0]      cnt_cur;
   logic [2:0]      tail_cnt;
   logic [7:0]      len_cur;
   logic            wide_cur;
   logic            first_cur;
   logic [63:0]     tail_word;

   assign req_ready = !push_full;
   assign accept    = req_valid && req_ready;
   assign active    = accept && (req_data.byte_present || req_data.message_end);

   assign cnt_cur   = open_ff ? count_ff : 3'd0;
   assign len_cur   = (open_ff ? len_ff : 8'd0) + {7'd0, req_data.byte_present};
   assign wide_cur  = open_ff ? wide_ff : wide_output;
   assign first_cur = open_ff ? first_ff : 1'b1;

   always_comb begin
      pend_new = pend_ff;
      tail_cnt = cnt_cur;
      if (req_data.byte_present && cnt_cur != 3'd7) begin
         pend_new[cnt_cur] = req_data.data_byte;
         tail_cnt          = cnt_cur + 3'd1;
      end
      tail_word = '0;
      for (int i = 0; i < 7; i++) begin
         tail_word[8*i +: 8] = (3'(i) < tail_cnt) ? pend_new[i] : 8'h00;
      end
      tail_word[63:56] = len_cur;
   end

   always_comb begin
      pend_in          = pend_ff;
      count_in         = count_ff;
      len_in           = len_ff;
      open_in          = open_ff;
      wide_in          = wide_ff;
      first_in         = first_ff;
      push_valid       = 1'b0;
      push_job.word    = {req_data.data_byte, pend_ff};
      push_job.pad_len = len_cur;
      push_job.first   = first_cur;
      push_job.wide    = wide_cur;
      push_job.kind    = JOB_WORD;
      if (active) begin
         len_in   = len_cur;
         wide_in  = wide_cur;
         first_in = first_cur;
         open_in  = !req_data.message_end;
         if (req_data.byte_present && cnt_cur == 3'd7) begin
            push_valid    = 1'b1;
            first_in      = 1'b0;
            count_in      = 3'd0;
            push_job.kind = req_data.message_end ? JOB_WORD_FINAL : JOB_WORD;
         end else begin
            pend_in  = pend_new;
            count_in = tail_cnt;
            if (req_data.message_end) begin
               push_valid    = 1'b1;
               first_in      = 1'b0;
               count_in      = 3'd0;
               push_job.word = tail_word;
               push_job.kind = JOB_FINAL;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      if (reset) begin
         count_ff <= '0;
         len_ff   <= '0;
         open_ff  <= 1'b0;
         wide_ff  <= 1'b0;
         first_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         len_ff   <= len_in;
         open_ff  <= open_in;
         wide_ff  <= wide_in;
         first_ff <= first_in;
      end
   end

endmodule

### sv/sh24_queue.sv
// Job queue between the front end and the round engine.
// Depends on sh24_pkg.
module sh24_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  sh24_pkg::job_type push_job,
   output logic              full,
   output logic              pop_valid,
   output sh24_pkg::job_type pop_job,
   input  logic              pop
);
   import sh24_pkg::*;

   job_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full      = count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_job   = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### sv/sh24_core.sv
// Round engine: one SipHash round per cycle for compression and
// finalization, with a registered result stage. Depends on sh24_pkg.
module sh24_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  sh24_pkg::job_type job,
   output logic              job_pop,
   input  logic [63:0]       key_low,
   input  logic [63:0]       key_high,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sh24_pkg::rsp_type rsp_data
);
   import sh24_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_COMP1 = 5'b00010,
      ST_COMP2 = 5'b00100,
      ST_FIN   = 5'b01000,
      ST_EMIT  = 5'b10000
   } core_state_type;

   core_state_type state_ff, state_in;
   sip_state_type  v_ff, v_in;
   logic [63:0]    m_ff, m_in;
   logic [7:0]     pad_ff, pad_in;
   job_kind_type   kind_ff, kind_in;
   logic           wide_ff, wide_in;
   logic           half_ff, half_in;
   logic [1:0]     rcnt_ff, rcnt_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_ff, rsp_in;

   sip_state_type  init;
   sip_state_type  round_src;
   sip_state_type  round_out;
   logic           emit;

   always_comb begin
      init[0] = key_low ^ INIT_C0;
      init[1] = key_high ^ INIT_C1 ^ {56'd0, job.wide ? TWEAK_WIDE : 8'h00};
      init[2] = key_low ^ INIT_C2;
      init[3] = key_high ^ INIT_C3;
      round_src = v_ff;
      if (state_ff == ST_IDLE) begin
         round_src    = job.first ? init : v_ff;
         round_src[3] = round_src[3] ^ job.word;
      end else if (state_ff == ST_COMP1) begin
         round_src[3] = v_ff[3] ^ m_ff;
      end
      round_out = sip_round(round_src);
   end

   always_comb begin
      state_in = state_ff;
      v_in     = v_ff;
      m_in     = m_ff;
      pad_in   = pad_ff;
      kind_in  = kind_ff;
      wide_in  = wide_ff;
      half_in  = half_ff;
      rcnt_in  = rcnt_ff;
      rsp_in   = rsp_ff;
      job_pop  = 1'b0;
      emit     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_pop  = 1'b1;
               v_in     = round_out;
               m_in     = job.word;
               pad_in   = job.pad_len;
               kind_in  = job.kind;
               wide_in  = job.wide;
               state_in = ST_COMP2;
            end
         end
         ST_COMP1: begin
            v_in     = round_out;
            state_in = ST_COMP2;
         end
         ST_COMP2: begin
            v_in    = round_out;
            v_in[0] = round_out[0] ^ m_ff;
            unique case (kind_ff)
               JOB_WORD: begin
                  state_in = ST_IDLE;
               end
               JOB_WORD_FINAL: begin
                  m_in     = {pad_ff, 56'd0};
                  kind_in  = JOB_FINAL;
                  state_in = ST_COMP1;
               end
               JOB_FINAL: begin
                  v_in[2]  = round_out[2] ^ {56'd0, wide_ff ? TWEAK_WIDE : TWEAK_NARROW};
                  rcnt_in  = 2'd0;
                  half_in  = 1'b0;
                  state_in = ST_FIN;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_FIN: begin
            v_in    = round_out;
            rcnt_in = rcnt_ff + 2'd1;
            if (rcnt_ff == 2'd3) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               emit              = 1'b1;
               rsp_in.hash_word  = fold(v_ff);
               rsp_in.final_word = !wide_ff || half_ff;
               if (wide_ff && !half_ff) begin
                  v_in[1]  = v_ff[1] ^ {56'd0, TWEAK_HIGH};
                  half_in  = 1'b1;
                  rcnt_in  = 2'd0;
                  state_in = ST_FIN;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      v_ff   <= v_in;
      m_ff   <= m_in;
      pad_ff <= pad_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         kind_ff      <= JOB_WORD;
         wide_ff      <= 1'b0;
         half_ff      <= 1'b0;
         rcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         wide_ff      <= wide_in;
         half_ff      <= half_in;
         rcnt_ff      <= rcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_fin_to_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && rcnt_ff == 2'd3) |=> state_ff == ST_EMIT)
      else $error("finalization did not end after four rounds");

   a_emit_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && rsp_valid_ff && !rsp_ready) |=> state_ff == ST_EMIT)
      else $error("result dropped while output stage was full");

   a_rise_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("result raised outside the emit state");

   a_half_only_wide: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && half_ff) |-> wide_ff)
      else $error("second half emitted in 64-bit mode");

endmodule

### sv/siphash_2_4_stream_unit.sv
// Top level of the SipHash-2-4 stream unit: key and mode registers, front
// end, job queue and round engine. Depends on sh24_pkg, sh24_front,
// sh24_queue and sh24_core.
//
// Takes one message byte per cycle. Bytes are packed into little-endian
// 64-bit words; each full word goes through a four-entry job queue to a
// round engine that runs one SipHash round per cycle, so byte input never
// waits in steady streaming. At a message end the engine compresses the
// last word (then a length word when the message length is a multiple of
// eight) and finalizes before the 64-bit hash appears, and again for the
// second word of the 128-bit hash; the input stalls only when the queue
// fills behind finalization or behind a result the receiver has not taken.
// The mode is sampled when a message opens and the key when the first word
// of the message reaches the engine; write them only while the unit is idle.
module siphash_2_4_stream_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  sh24_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output sh24_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_write_en,
   input  logic [sh24_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [63:0]                           csr_wdata
);
   import sh24_pkg::*;

   logic [63:0] key_low_ff, key_low_in;
   logic [63:0] key_high_ff, key_high_in;
   logic        wide_output_ff, wide_output_in;

   logic        push_valid;
   job_type     push_job;
   logic        queue_full;
   logic        job_valid;
   job_type     job;
   logic        job_pop;

   always_comb begin
      key_low_in     = key_low_ff;
      key_high_in    = key_high_ff;
      wide_output_in = wide_output_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_KEY_LOW:     key_low_in     = csr_wdata;
            CSR_KEY_HIGH:    key_high_in    = csr_wdata;
            CSR_WIDE_OUTPUT: wide_output_in = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff     <= '0;
         key_high_ff    <= '0;
         wide_output_ff <= 1'b0;
      end else begin
         key_low_ff     <= key_low_in;
         key_high_ff    <= key_high_in;
         wide_output_ff <= wide_output_in;
      end
   end

   sh24_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .wide_output (wide_output_ff),
      .push_valid  (push_valid),
      .push_job    (push_job),
      .push_full   (queue_full)
   );

   sh24_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .full       (queue_full),
      .pop_valid  (job_valid),
      .pop_job    (job),
      .pop        (job_pop)
   );

   sh24_core u_core (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job       (job),
      .job_pop   (job_pop),
      .key_low   (key_low_ff),
      .key_high  (key_high_ff),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
